@@ sv/oaht_pkg.sv @@
// Shared codes and slot layout for the open-addressing hash table.
package oaht_pkg;

  localparam logic [1:0] KIND_GET = 2'd0;
  localparam logic [1:0] KIND_SET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [2:0] KT_BOOL   = 3'd0;
  localparam logic [2:0] KT_INT    = 3'd1;
  localparam logic [2:0] KT_FLOAT  = 3'd2;
  localparam logic [2:0] KT_OBJECT = 3'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_TRUE_HASH   = 2'd1;
  localparam logic [1:0] CFG_FALSE_HASH  = 2'd2;

  localparam logic [9:0]  MAX_ENTRIES_RST = 10'd768;
  localparam logic [31:0] TRUE_HASH_RST   = 32'd1;
  localparam logic [31:0] FALSE_HASH_RST  = 32'd0;

  typedef struct packed {
    logic [1:0]  mark;
    logic [1:0]  key_type;
    logic [63:0] key;
    logic [2:0]  value_type;
    logic [63:0] value;
  } slot_t;

  localparam int ENTRY_W = $bits(slot_t);

endpackage

@@ sv/open_addressing_hash_table_top.sv @@
// Open-addressing key/value table with linear probing and tombstones.
// An accepted item has its home slot computed and then probes slots from there until
// a match, an empty slot or a full sweep; the slot memory delivers one slot per
// cycle and reads the next slot while the current one is checked. When SLOTS is not
// a power of two the home index is reduced eight hash bits a cycle. An invalid key
// type or kind skips hashing and probing. No new item is accepted until the current
// one is answered, and a stalled result word holds that answer back. After reset a
// clearing pass writes every slot, one a cycle, during which no item is accepted;
// configuration writes are taken anytime.
module open_addressing_hash_table_top
  import oaht_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_key_type,
  input  logic [63:0] in_key_bits,
  input  logic [31:0] in_key_hash,
  input  logic [2:0]  in_value_type,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_new_key,
  output logic [2:0]  out_read_type,
  output logic [63:0] out_read_bits,
  output logic [10:0] out_filled_slots,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PR_FOUND,
    PR_EMPTY,
    PR_NONE
  } probe_t;

  state_t state_r;

  logic [9:0]  max_entries_r;
  logic [31:0] true_hash_r;
  logic [31:0] false_hash_r;

  logic [1:0]  kind_r;
  logic [2:0]  type_r;
  logic [63:0] key_r;
  logic [2:0]  vtype_r;
  logic [63:0] vbits_r;
  logic        inv_r;

  logic [IW-1:0] clr_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] eval_idx_r;
  logic [IW-1:0] cnt_r;
  logic          rd_pend_r;
  logic          have_tomb_r;
  logic [IW-1:0] tomb_r;
  logic [IW-1:0] slot_r;
  probe_t        pr_r;
  logic [2:0]    fvtype_r;
  logic [63:0]   fval_r;
  logic [10:0]   used_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_new_key_r;
  logic [2:0]  out_read_type_r;
  logic [63:0] out_read_bits_r;
  logic [10:0] out_filled_r;

  logic          in_acc;
  logic          in_bad;
  logic [31:0]   in_hash;
  logic          home_done;
  logic [IW-1:0] home;
  logic          out_free;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  slot_t               rd_ent;
  logic                rd_match;

  logic [1:0]    st_nxt;
  logic          newk_nxt;
  logic [2:0]    rtype_nxt;
  logic [63:0]   rbits_nxt;
  logic [10:0]   used_nxt;
  logic          wr_go;
  logic [IW-1:0] wr_slot;
  slot_t         wr_ent;

  function automatic logic is_nan(input logic [63:0] b);
    return (&b[62:52]) && (|b[51:0]);
  endfunction

  function automatic logic float_eq(input logic [63:0] a, input logic [63:0] b);
    return !is_nan(a) && !is_nan(b) && ((a == b) || (a[62:0] == '0 && b[62:0] == '0));
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_bad    = (in_key_type > KT_OBJECT) || (in_kind > KIND_DEL);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    case (in_key_type)
      KT_BOOL:   in_hash = in_key_bits[0] ? true_hash_r : false_hash_r;
      KT_OBJECT: in_hash = in_key_hash;
      default:   in_hash = in_key_bits[31:0] ^ in_key_bits[63:32];
    endcase
  end

  oaht_home #(.SLOTS(SLOTS)) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && !in_bad),
    .hash  (in_hash),
    .done  (home_done),
    .home  (home)
  );

  assign rd_ent = slot_t'(ram_rdata);

  always_comb begin
    case (type_r)
      KT_BOOL:  rd_match = rd_ent.key[0] == key_r[0];
      KT_FLOAT: rd_match = float_eq(rd_ent.key, key_r);
      default:  rd_match = rd_ent.key == key_r;
    endcase
    rd_match = rd_match && (rd_ent.mark == MARK_LIVE) && (rd_ent.key_type == type_r[1:0]);
  end

  always_comb begin
    st_nxt    = ST_DONE;
    newk_nxt  = 1'b0;
    rtype_nxt = '0;
    rbits_nxt = '0;
    used_nxt  = used_r;
    wr_go     = 1'b0;
    wr_slot   = slot_r;
    wr_ent    = '{mark: MARK_LIVE, key_type: type_r[1:0], key: key_r,
                  value_type: vtype_r, value: vbits_r};
    if (inv_r) begin
      st_nxt = ST_INVALID;
    end else begin
      case (kind_r)
        KIND_GET: begin
          if (pr_r == PR_FOUND) begin
            rtype_nxt = fvtype_r;
            rbits_nxt = fval_r;
          end else begin
            st_nxt = ST_NOT_FOUND;
          end
        end
        KIND_DEL: begin
          if (pr_r == PR_FOUND) begin
            wr_go  = 1'b1;
            wr_ent = '{mark: MARK_TOMB, key_type: 2'd0, key: 64'd0,
                       value_type: 3'd0, value: 64'd0};
          end else begin
            st_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
          if (pr_r == PR_FOUND) begin
            wr_go = 1'b1;
          end else if (have_tomb_r) begin
            wr_go    = 1'b1;
            wr_slot  = tomb_r;
            newk_nxt = 1'b1;
          end else if (pr_r == PR_EMPTY && used_r < {1'b0, max_entries_r}) begin
            wr_go    = 1'b1;
            newk_nxt = 1'b1;
            used_nxt = used_r + 11'd1;
          end else begin
            st_nxt = ST_FULL;
          end
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_slot;
    ram_wdata = ENTRY_W'(wr_ent);
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == S_DONE && out_free) begin
      ram_we = wr_go;
    end
  end

  assign ram_re = (state_r == S_PROBE);

  oaht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
      true_hash_r   <= TRUE_HASH_RST;
      false_hash_r  <= FALSE_HASH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ENTRIES: max_entries_r <= cfg_data[9:0];
        CFG_TRUE_HASH:   true_hash_r   <= cfg_data;
        CFG_FALSE_HASH:  false_hash_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      rd_pend_r   <= 1'b0;
      have_tomb_r <= 1'b0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            kind_r  <= in_kind;
            type_r  <= in_key_type;
            key_r   <= (in_key_type == KT_BOOL) ? {63'd0, in_key_bits[0]} : in_key_bits;
            vtype_r <= in_value_type;
            vbits_r <= in_value_bits;
            inv_r   <= in_bad;
            state_r <= in_bad ? S_DONE : S_HASH;
          end
        end
        S_HASH: begin
          if (home_done) begin
            idx_r       <= home;
            cnt_r       <= '0;
            rd_pend_r   <= 1'b0;
            have_tomb_r <= 1'b0;
            state_r     <= S_PROBE;
          end
        end
        S_PROBE: begin
          idx_r      <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
          eval_idx_r <= idx_r;
          rd_pend_r  <= 1'b1;
          if (rd_pend_r) begin
            slot_r   <= eval_idx_r;
            fvtype_r <= rd_ent.value_type;
            fval_r   <= rd_ent.value;
            cnt_r    <= cnt_r + 1'b1;
            if (rd_match) begin
              pr_r    <= PR_FOUND;
              state_r <= S_DONE;
            end else if (rd_ent.mark == MARK_EMPTY) begin
              pr_r    <= PR_EMPTY;
              state_r <= S_DONE;
            end else begin
              if (rd_ent.mark != MARK_LIVE && !have_tomb_r) begin
                have_tomb_r <= 1'b1;
                tomb_r      <= eval_idx_r;
              end
              if (cnt_r == LAST_IDX) begin
                pr_r    <= PR_NONE;
                state_r <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            used_r          <= used_nxt;
            out_valid_r     <= 1'b1;
            out_status_r    <= st_nxt;
            out_new_key_r   <= newk_nxt;
            out_read_type_r <= rtype_nxt;
            out_read_bits_r <= rbits_nxt;
            out_filled_r    <= used_nxt;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_new_key      = out_new_key_r;
  assign out_read_type    = out_read_type_r;
  assign out_read_bits    = out_read_bits_r;
  assign out_filled_slots = out_filled_r;

endmodule

@@ sv/oaht_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/oaht_home.sv @@
// Home slot unit: reduces a 32-bit hash modulo the slot count.
module oaht_home #(
  parameter int SLOTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              hash,
  output logic                     done,
  output logic [$clog2(SLOTS)-1:0] home
);

  localparam int IW = $clog2(SLOTS);
  localparam int RW = IW + 1;
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [RW-1:0] SLOTS_W = RW'(SLOTS);

  logic          busy_r;
  logic [1:0]    step_r;
  logic [31:0]   hash_sh_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_nxt;
  logic          done_r;
  logic [IW-1:0] home_r;

  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < 8; i++) begin
      rem_nxt = {rem_nxt[RW-2:0], hash_sh_r[31-i]};
      if (rem_nxt >= SLOTS_W) begin
        rem_nxt = rem_nxt - SLOTS_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (POW2) begin
          home_r <= hash[IW-1:0];
          done_r <= 1'b1;
        end else begin
          busy_r    <= 1'b1;
          step_r    <= '0;
          hash_sh_r <= hash;
          rem_r     <= '0;
        end
      end else if (busy_r) begin
        rem_r     <= rem_nxt;
        hash_sh_r <= {hash_sh_r[23:0], 8'd0};
        step_r    <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          home_r <= rem_nxt[IW-1:0];
        end
      end
    end
  end

  assign done = done_r;
  assign home = home_r;

endmodule

@@ test/tb_open_addressing_hash_table_top.sv @@
// Self-checking testbench for the hash table: directed and random words vs. a predictor.
module tb_open_addressing_hash_table_top;
  import oaht_pkg::*;

  localparam int SLOTS = 1024;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] KT_INVALID = 3'd4;
  localparam logic [2:0] KT_TAG_MAX = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  key_type;
    logic [63:0] key_bits;
    logic [31:0] key_hash;
    logic [2:0]  value_type;
    logic [63:0] value_bits;
  } op_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        new_key;
    logic [2:0]  read_type;
    logic [63:0] read_bits;
    logic [10:0] filled;
  } reply_t;

  typedef struct packed {
    op_word_t    op;
    logic        fixed;
    reply_t      want;
    logic        cfg_en;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_val;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [2:0]  in_key_type = '0;
  logic [63:0] in_key_bits = '0;
  logic [31:0] in_key_hash = '0;
  logic [2:0]  in_value_type = '0;
  logic [63:0] in_value_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_new_key;
  logic [2:0]  out_read_type;
  logic [63:0] out_read_bits;
  logic [10:0] out_filled_slots;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [1:0]  tbl_mark [SLOTS];
  logic [1:0]  tbl_key_type [SLOTS];
  logic [63:0] tbl_key [SLOTS];
  logic [2:0]  tbl_value_type [SLOTS];
  logic [63:0] tbl_value [SLOTS];
  int unsigned used_slots;
  logic [9:0]  max_entries_q;
  logic [31:0] true_hash_q;
  logic [31:0] false_hash_q;

  logic [63:0] key_pool [64];
  logic [31:0] hash_pool [64];
  reply_t      awaited_replies [$];
  reply_t      head_reply;
  plan_row_t   plan [$];
  bit          idling = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;

  open_addressing_hash_table_top #(.SLOTS(SLOTS)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_key_type      (in_key_type),
    .in_key_bits      (in_key_bits),
    .in_key_hash      (in_key_hash),
    .in_value_type    (in_value_type),
    .in_value_bits    (in_value_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_new_key      (out_new_key),
    .out_read_type    (out_read_type),
    .out_read_bits    (out_read_bits),
    .out_filled_slots (out_filled_slots),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic bit is_nan(logic [63:0] b);
    return b[62:52] == 11'h7FF && b[51:0] != '0;
  endfunction

  function automatic bit keys_match(int unsigned s, logic [2:0] kt, logic [63:0] k);
    if (tbl_key_type[s] != kt[1:0]) return 1'b0;
    case (kt)
      KT_BOOL: return tbl_key[s][0] == k[0];
      KT_FLOAT: begin
        if (is_nan(tbl_key[s]) || is_nan(k)) return 1'b0;
        if (tbl_key[s] == k) return 1'b1;
        return tbl_key[s][62:0] == '0 && k[62:0] == '0;
      end
      default: return tbl_key[s] == k;
    endcase
  endfunction

  function automatic reply_t compute_reply(op_word_t w);
    reply_t      r;
    logic [63:0] k;
    logic [31:0] h;
    int unsigned idx, slot, tomb, n;
    bit          found, hit_empty, have_tomb, ok;
    r = '0;
    k = w.key_bits;
    if (w.key_type > KT_OBJECT || w.kind > KIND_DEL) begin
      r.status = ST_INVALID;
    end else begin
      case (w.key_type)
        KT_BOOL: begin
          k = {63'd0, k[0]};
          h = k[0] ? true_hash_q : false_hash_q;
        end
        KT_OBJECT: h = w.key_hash;
        default: h = k[31:0] ^ k[63:32];
      endcase
      idx = h % 32'(SLOTS);
      found = 1'b0;
      hit_empty = 1'b0;
      have_tomb = 1'b0;
      slot = 0;
      tomb = 0;
      for (n = 0; n < SLOTS && !found && !hit_empty; n++) begin
        if (tbl_mark[idx] == MARK_LIVE) begin
          if (keys_match(idx, w.key_type, k)) begin
            found = 1'b1;
            slot = idx;
          end
        end else if (tbl_mark[idx] == MARK_EMPTY) begin
          hit_empty = 1'b1;
          slot = idx;
        end else if (!have_tomb) begin
          have_tomb = 1'b1;
          tomb = idx;
        end
        idx = (idx + 1) % SLOTS;
      end
      case (w.kind)
        KIND_GET: begin
          if (found) begin
            r.read_type = tbl_value_type[slot];
            r.read_bits = tbl_value[slot];
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        KIND_DEL: begin
          if (found) begin
            tbl_mark[slot] = MARK_TOMB;
            tbl_key_type[slot] = '0;
            tbl_key[slot] = '0;
            tbl_value_type[slot] = '0;
            tbl_value[slot] = '0;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: begin
          ok = 1'b1;
          if (!found) begin
            if (have_tomb) begin
              slot = tomb;
            end else if (hit_empty && used_slots < max_entries_q) begin
              used_slots++;
            end else begin
              ok = 1'b0;
            end
            r.new_key = ok;
          end
          if (ok) begin
            tbl_mark[slot] = MARK_LIVE;
            tbl_key_type[slot] = w.key_type[1:0];
            tbl_key[slot] = k;
            tbl_value_type[slot] = w.value_type;
            tbl_value[slot] = w.value_bits;
          end else begin
            r.status = ST_FULL;
          end
        end
      endcase
    end
    r.filled = used_slots[10:0];
    return r;
  endfunction

  function automatic op_word_t op(logic [1:0] kind, logic [2:0] kt, logic [63:0] key,
                                  logic [31:0] hash = '0, logic [2:0] vt = '0,
                                  logic [63:0] vb = '0);
    op_word_t w;
    w = '{kind, kt, key, hash, vt, vb};
    return w;
  endfunction

  function automatic plan_row_t row(op_word_t o, logic fixed = 1'b0, reply_t want = '0,
                                    logic cfg_en = 1'b0,
                                    logic [1:0] cfg_idx = CFG_MAX_ENTRIES,
                                    logic [31:0] cfg_val = '0);
    plan_row_t p;
    p = '{o, fixed, want, cfg_en, cfg_idx, cfg_val};
    return p;
  endfunction

  function automatic op_word_t random_word();
    op_word_t    w;
    int unsigned pick, r;
    pick = $urandom_range(0, 63);
    r = $urandom_range(0, 99);
    w.kind = r < 35 ? KIND_GET : r < 75 ? KIND_SET : r < 95 ? KIND_DEL : KIND_UNUSED;
    r = $urandom_range(0, 99);
    w.key_type = r < 15 ? KT_BOOL : r < 45 ? KT_INT : r < 70 ? KT_FLOAT :
                 r < 95 ? KT_OBJECT : 3'($urandom_range(KT_INVALID, KT_TAG_MAX));
    w.key_bits = $urandom_range(0, 4) == 0 ? {$urandom, $urandom} : key_pool[pick];
    w.key_hash = $urandom_range(0, 6) == 0 ? $urandom : hash_pool[pick];
    w.value_type = 3'($urandom_range(0, 7));
    w.value_bits = {$urandom, $urandom};
    return w;
  endfunction

  function automatic void check_field(string label, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, label, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic push_word(op_word_t w, logic fixed = 1'b0, reply_t want = '0);
    reply_t got;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= w.kind;
    in_key_type   <= w.key_type;
    in_key_bits   <= w.key_bits;
    in_key_hash   <= w.key_hash;
    in_value_type <= w.value_type;
    in_value_bits <= w.value_bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = compute_reply(w);
    awaited_replies.push_back(fixed ? want : got);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_ENTRIES: max_entries_q = val[9:0];
      CFG_TRUE_HASH: true_hash_q = val;
      default: false_hash_q = val;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(logic [9:0] max_e, logic [31:0] t_hash, logic [31:0] f_hash,
                           int count, bit calm);
    int i;
    drain();
    write_reg(CFG_MAX_ENTRIES, {22'd0, max_e});
    write_reg(CFG_TRUE_HASH, t_hash);
    write_reg(CFG_FALSE_HASH, f_hash);
    for (i = 0; i < count; i++) begin
      idling <= !calm && (i % 100) < 75;
      push_word(random_word());
    end
  endtask

  always @(posedge clk) begin
    if (!idling) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected word status %h filled %h", $time, out_status,
                 out_filled_slots);
        mismatches++;
      end else begin
        head_reply = awaited_replies.pop_front();
        check_field("status", head_reply.status, out_status);
        check_field("new_key", head_reply.new_key, out_new_key);
        check_field("read_type", head_reply.read_type, out_read_type);
        check_field("read_bits", head_reply.read_bits, out_read_bits);
        check_field("filled_slots", head_reply.filled, out_filled_slots);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_open_addressing_hash_table_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          s;
    logic [31:0] h;
    logic [31:0] hi;
    for (s = 0; s < SLOTS; s++) begin
      tbl_mark[s] = MARK_EMPTY;
      tbl_key_type[s] = '0;
      tbl_key[s] = '0;
      tbl_value_type[s] = '0;
      tbl_value[s] = '0;
    end
    used_slots = 0;
    max_entries_q = MAX_ENTRIES_RST;
    true_hash_q = TRUE_HASH_RST;
    false_hash_q = FALSE_HASH_RST;

    // cluster homes near slot zero and at the top so probes run long and wrap
    for (s = 0; s < 64; s++) begin
      h = ($urandom & 32'hFFFF_FC00) |
          ((s % 4 == 0) ? $urandom_range(SLOTS - 4, SLOTS - 1) : $urandom_range(0, 31));
      hi = $urandom;
      key_pool[s] = {hi, hi ^ h};
      hash_pool[s] = h;
    end
    key_pool[0] = 64'd0;
    key_pool[1] = 64'h8000_0000_0000_0000;
    key_pool[2] = 64'h7FF8_0000_0000_0001;
    key_pool[3] = 64'h7FF0_0000_0000_0000;
    key_pool[4] = '1;

    plan.push_back(row(op(KIND_GET, KT_INT, 64'd0), 1'b1,
                       {ST_NOT_FOUND, 1'b0, 3'd0, 64'd0, 11'd0}));
    plan.push_back(row(op(KIND_SET, KT_BOOL, 64'd1, '0, 3'd7, '1), 1'b1,
                       {ST_DONE, 1'b1, 3'd0, 64'd0, 11'd1}));
    plan.push_back(row(op(KIND_SET, KT_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, '0, 3'd0,
                          64'h0123_4567_89AB_CDEF), 1'b1,
                       {ST_DONE, 1'b1, 3'd0, 64'd0, 11'd2}));
    plan.push_back(row(op(KIND_GET, KT_BOOL, '1), 1'b1,
                       {ST_DONE, 1'b0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 11'd2}));
    plan.push_back(row(op(KIND_SET, KT_INT, 64'h0000_0001_0000_0001, '0, 3'd1, 64'd11)));
    plan.push_back(row(op(KIND_SET, KT_FLOAT, 64'd0, '0, 3'd2, 64'd22)));
    plan.push_back(row(op(KIND_GET, KT_FLOAT, 64'h8000_0000_0000_0000)));
    plan.push_back(row(op(KIND_SET, KT_FLOAT, 64'h7FF8_0000_0000_0001, '0, 3'd3, 64'd33)));
    plan.push_back(row(op(KIND_SET, KT_FLOAT, 64'h7FF8_0000_0000_0001, '0, 3'd3, 64'd44)));
    plan.push_back(row(op(KIND_GET, KT_FLOAT, 64'h7FF8_0000_0000_0001)));
    plan.push_back(row(op(KIND_DEL, KT_BOOL, 64'd0)));
    plan.push_back(row(op(KIND_DEL, KT_BOOL, 64'd2)));
    plan.push_back(row(op(KIND_SET, KT_INT, '1, '0, 3'd4, 64'd55)));
    plan.push_back(row(op(KIND_SET, KT_OBJECT, '1, '1, 3'd5, 64'h8000_0000_0000_0000)));
    plan.push_back(row(op(KIND_SET, KT_OBJECT, 64'd0, '1, 3'd6, 64'd66)));
    plan.push_back(row(op(KIND_GET, KT_INVALID, 64'd5)));
    plan.push_back(row(op(KIND_SET, KT_TAG_MAX, '1, '1, 3'd7, '1)));
    plan.push_back(row(op(KIND_UNUSED, KT_INT, 64'd0)));
    plan.push_back(row(op(KIND_GET, KT_OBJECT, '1, '1)));
    plan.push_back(row(op(KIND_SET, KT_INT, 64'd42, '0, 3'd1, 64'd42), 1'b0, '0,
                       1'b1, CFG_MAX_ENTRIES, 32'd1));
    plan.push_back(row(op(KIND_SET, KT_INT, '1, '0, 3'd0, 64'd77)));
    plan.push_back(row(op(KIND_DEL, KT_OBJECT, 64'd0, '1)));
    plan.push_back(row(op(KIND_SET, KT_OBJECT, 64'h55, '1, 3'd2, 64'd88)));
    plan.push_back(row(op(KIND_SET, KT_BOOL, 64'd1, '0, 3'd1, 64'd99), 1'b0, '0,
                       1'b1, CFG_TRUE_HASH, '1));
    plan.push_back(row(op(KIND_GET, KT_BOOL, 64'd0), 1'b0, '0,
                       1'b1, CFG_FALSE_HASH, '1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idling <= 1'b1;
    foreach (plan[j]) begin
      if (plan[j].cfg_en) begin
        drain();
        write_reg(plan[j].cfg_idx, plan[j].cfg_val);
      end
      push_word(plan[j].op, plan[j].fixed, plan[j].want);
    end

    run_phase(10'd1023, 32'hFFFF_FFFF, 32'd0, 300, 1'b0);
    run_phase(10'(used_slots + 10), $urandom, $urandom, 250, 1'b0);
    run_phase(10'd1, $urandom, $urandom, 200, 1'b0);
    run_phase(MAX_ENTRIES_RST, $urandom, $urandom, 150, 1'b1);
    drain();
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_open_addressing_hash_table_top: PASS");
    end else begin
      $display("tb_open_addressing_hash_table_top: FAIL");
    end
    $finish;
  end

endmodule

@@ open_addressing_hash_table_top.f @@
sv/oaht_pkg.sv
sv/oaht_ram.sv
sv/oaht_home.sv
sv/open_addressing_hash_table_top.sv
test/tb_open_addressing_hash_table_top.sv
